// ----- src/msefd_pkg.sv -----
// Shared widths, byte codes and frame lengths for the escaped-frame deframer.
package msefd_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned TS_W   = 48;
   localparam int unsigned PAY_W  = 56;
   localparam int unsigned POS_W  = 5;

   localparam int unsigned TS_BYTES    = TS_W / BYTE_W;
   localparam int unsigned HEAD_LEN    = TS_BYTES + 1;
   localparam int unsigned SHORT_BYTES = PAY_W / BYTE_W;
   localparam int unsigned LONG_BYTES  = 2 * SHORT_BYTES;
   localparam int unsigned STORE_W     = LONG_BYTES * BYTE_W;

   localparam logic [POS_W-1:0] SHORT_TOTAL = POS_W'(HEAD_LEN + SHORT_BYTES);
   localparam logic [POS_W-1:0] LONG_TOTAL  = POS_W'(HEAD_LEN + LONG_BYTES);
   localparam logic [POS_W-1:0] LEVEL_POS   = POS_W'(TS_BYTES);

   localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'h1a;
   localparam logic [BYTE_W-1:0] TYPE_SHORT = 8'h32;
   localparam logic [BYTE_W-1:0] TYPE_LONG  = 8'h33;
   localparam logic [BYTE_W-1:0] LEVEL_MAX  = 8'hff;

endpackage

// ----- src/msefd_if.sv -----
// Request and response channel interfaces of the escaped-frame deframer.
interface msefd_req_if
   import msefd_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface msefd_rsp_if
   import msefd_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              frame_kind;
   logic [TS_W-1:0]   timestamp;
   logic [BYTE_W-1:0] signal_level;
   logic [PAY_W-1:0]  payload_first;
   logic [PAY_W-1:0]  payload_second;

   modport source (output valid, output frame_kind, output timestamp,
                   output signal_level, output payload_first, output payload_second,
                   input ready);
   modport sink (input valid, input frame_kind, input timestamp,
                 input signal_level, input payload_first, input payload_second,
                 output ready);
endinterface

// ----- src/mode_s_escaped_frame_deframer.sv -----
// Top level of the escaped-frame deframer: byte unescaping, frame collection and result register.
// Latency: a result is valid in the cycle after the request that carries the last frame byte.
// Throughput: one request per cycle; req_chan.ready drops only while a result waits and
// rsp_chan.ready is low, since the single result register is the only buffering.
// Reset is synchronous and active high; it returns the deframer to hunting and clears
// the result valid. Timestamp, signal and payload registers are not reset.
module mode_s_escaped_frame_deframer
   import msefd_pkg::*;
   (
   input  logic          clock,
   input  logic          reset,
   msefd_req_if.sink     req_chan,
   msefd_rsp_if.source   rsp_chan
   );

   localparam logic [1:0] PH_HUNT  = 2'd0;
   localparam logic [1:0] PH_TYPE  = 2'd1;
   localparam logic [1:0] PH_FRAME = 2'd2;

   logic [1:0]         phase_ff, phase_in;
   logic               esc_ff, esc_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               kind_ff, kind_in;
   logic [TS_W-1:0]    time_ff, time_in;
   logic [BYTE_W-1:0]  level_ff, level_in;
   logic [STORE_W-1:0] store_ff, store_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [TS_W-1:0]    rsp_time_ff, rsp_time_in;
   logic [BYTE_W-1:0]  rsp_level_ff, rsp_level_in;
   logic [PAY_W-1:0]   rsp_first_ff, rsp_first_in;
   logic [PAY_W-1:0]   rsp_second_ff, rsp_second_in;

   logic               req_ready;
   logic               accept;
   logic [BYTE_W-1:0]  rx;
   logic               data_take;
   logic               frame_done;
   logic [POS_W-1:0]   pos_inc;
   logic [POS_W-1:0]   total;

   assign req_ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept    = req_chan.valid && req_ready;
   assign rx        = req_chan.rx_byte;
   assign pos_inc   = pos_ff + POS_W'(1);
   assign total     = kind_ff ? LONG_TOTAL : SHORT_TOTAL;

   assign data_take = accept && (phase_ff == PH_FRAME)
                      && (esc_ff ? (rx == ESC_BYTE) : (rx != ESC_BYTE));
   assign frame_done = data_take && (pos_inc == total);

   always_comb begin
      phase_in = phase_ff;
      esc_in   = esc_ff;
      pos_in   = pos_ff;
      kind_in  = kind_ff;
      time_in  = time_ff;
      level_in = level_ff;
      store_in = store_ff;
      if (accept) begin
         case (phase_ff)
            PH_TYPE: begin
               esc_in = 1'b0;
               pos_in = '0;
               if (rx == TYPE_SHORT || rx == TYPE_LONG) begin
                  kind_in  = (rx == TYPE_LONG);
                  time_in  = '0;
                  phase_in = PH_FRAME;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_FRAME: begin
               if (data_take) begin
                  esc_in = 1'b0;
                  if (pos_ff < LEVEL_POS) begin
                     time_in = {time_ff[TS_W-BYTE_W-1:0], rx};
                  end else if (pos_ff == LEVEL_POS) begin
                     level_in = rx;
                  end else begin
                     store_in = {store_ff[STORE_W-BYTE_W-1:0], rx};
                  end
                  if (frame_done) begin
                     phase_in = PH_HUNT;
                     pos_in   = '0;
                  end else begin
                     pos_in = pos_inc;
                  end
               end else if (esc_ff) begin
                  // A lone escape abandons the frame; this byte is the new type byte.
                  esc_in = 1'b0;
                  pos_in = '0;
                  if (rx == TYPE_SHORT || rx == TYPE_LONG) begin
                     kind_in  = (rx == TYPE_LONG);
                     time_in  = '0;
                     phase_in = PH_FRAME;
                  end else begin
                     phase_in = PH_HUNT;
                  end
               end else begin
                  esc_in = 1'b1;
               end
            end
            default: begin
               phase_in = (rx == ESC_BYTE) ? PH_TYPE : PH_HUNT;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_time_in   = rsp_time_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      if (frame_done) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = kind_ff;
         rsp_time_in  = time_ff;
         rsp_level_in = (level_ff == LEVEL_MAX) ? '0 : level_ff;
         if (kind_ff) begin
            rsp_first_in  = store_in[STORE_W-1:PAY_W];
            rsp_second_in = store_in[PAY_W-1:0];
         end else begin
            rsp_first_in  = store_in[PAY_W-1:0];
            rsp_second_in = '0;
         end
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         esc_ff       <= 1'b0;
         pos_ff       <= '0;
         kind_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         esc_ff       <= esc_in;
         pos_ff       <= pos_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      time_ff       <= time_in;
      level_ff      <= level_in;
      store_ff      <= store_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
   end

   assign req_chan.ready         = req_ready;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.frame_kind    = rsp_kind_ff;
   assign rsp_chan.timestamp     = rsp_time_ff;
   assign rsp_chan.signal_level  = rsp_level_ff;
   assign rsp_chan.payload_first = rsp_first_ff;
   assign rsp_chan.payload_second = rsp_second_ff;

   a_esc_in_frame: assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> (phase_ff == PH_FRAME))
      else $error("escape pending outside a frame");

   a_pos_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_FRAME) |-> (pos_ff == '0))
      else $error("byte position not cleared outside a frame");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_FRAME) |-> (pos_ff < total))
      else $error("byte position past frame end");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(phase_ff) == PH_FRAME && $past(accept)))
      else $error("result raised without a frame byte");

   a_short_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_kind_ff) |-> (rsp_second_ff == '0))
      else $error("short frame with nonzero second payload");

endmodule

// ----- sim/msefd_frame_checker.sv -----
// Frame predictor and result checker that watches both channels of the escaped-frame deframer.
`timescale 1ns / 1ps

module msefd_frame_checker
   import msefd_pkg::*;
   (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [BYTE_W-1:0] req_rx_byte,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              rsp_frame_kind,
   input  logic [TS_W-1:0]   rsp_timestamp,
   input  logic [BYTE_W-1:0] rsp_signal_level,
   input  logic [PAY_W-1:0]  rsp_payload_first,
   input  logic [PAY_W-1:0]  rsp_payload_second,
   output int                mismatches,
   output int                outstanding,
   output int                frames_checked
   );

   typedef enum logic [1:0] {HUNTING, WANT_TYPE, IN_FRAME} deframe_phase_type;

   typedef struct {
      logic              kind;
      logic [TS_W-1:0]   ts;
      logic [BYTE_W-1:0] level;
      logic [PAY_W-1:0]  first;
      logic [PAY_W-1:0]  second;
   } frame_type;

   frame_type         frames_due[$];
   deframe_phase_type phase;
   logic              esc_seen;
   int unsigned       fill;
   logic              kind_now;
   logic [TS_W-1:0]   ts_acc;
   logic [BYTE_W-1:0] level_acc;
   logic [BYTE_W-1:0] pay_acc [LONG_BYTES];
   int                bad_count;
   int                checked_count;

   // The byte after a frame start selects the frame kind; anything else sends us hunting.
   task automatic open_frame(input logic [BYTE_W-1:0] b);
      esc_seen = 1'b0;
      fill = 0;
      if (b == TYPE_SHORT || b == TYPE_LONG) begin
         kind_now = (b == TYPE_LONG);
         ts_acc = '0;
         phase = IN_FRAME;
      end else begin
         phase = HUNTING;
      end
   endtask

   task automatic collect_byte(input logic [BYTE_W-1:0] b);
      int unsigned total;
      frame_type   f;
      total = HEAD_LEN + (kind_now ? LONG_BYTES : SHORT_BYTES);
      if (fill < TS_BYTES) begin
         ts_acc = {ts_acc[TS_W-BYTE_W-1:0], b};
      end else if (fill == TS_BYTES) begin
         level_acc = b;
      end else begin
         pay_acc[fill - HEAD_LEN] = b;
      end
      fill++;
      if (fill >= total) begin
         f.kind = kind_now;
         f.ts = ts_acc;
         f.level = (level_acc == LEVEL_MAX) ? '0 : level_acc;
         f.first = '0;
         f.second = '0;
         for (int i = 0; i < SHORT_BYTES; i++) begin
            f.first = {f.first[PAY_W-BYTE_W-1:0], pay_acc[i]};
            if (kind_now) begin
               f.second = {f.second[PAY_W-BYTE_W-1:0], pay_acc[i + SHORT_BYTES]};
            end
         end
         frames_due.push_back(f);
         phase = HUNTING;
         esc_seen = 1'b0;
         fill = 0;
      end
   endtask

   task automatic absorb_rx_byte(input logic [BYTE_W-1:0] b);
      case (phase)
         WANT_TYPE: begin
            open_frame(b);
         end
         IN_FRAME: begin
            if (esc_seen) begin
               esc_seen = 1'b0;
               if (b == ESC_BYTE) begin
                  collect_byte(b);
               end else begin
                  open_frame(b);
               end
            end else if (b == ESC_BYTE) begin
               esc_seen = 1'b1;
            end else begin
               collect_byte(b);
            end
         end
         default: begin
            phase = (b == ESC_BYTE) ? WANT_TYPE : HUNTING;
         end
      endcase
   endtask

   always @(posedge clock) begin
      frame_type want;
      if (reset) begin
         frames_due.delete();
         phase = HUNTING;
         esc_seen = 1'b0;
         fill = 0;
         kind_now = 1'b0;
         ts_acc = '0;
         level_acc = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (frames_due.size() == 0) begin
               bad_count++;
               if (bad_count <= 10) begin
                  $display("%0t: unexpected frame: kind %0d ts %h level %h pay %h %h", $realtime,
                           rsp_frame_kind, rsp_timestamp, rsp_signal_level,
                           rsp_payload_first, rsp_payload_second);
               end
            end else begin
               want = frames_due.pop_front();
               checked_count++;
               if (rsp_frame_kind !== want.kind || rsp_timestamp !== want.ts ||
                   rsp_signal_level !== want.level || rsp_payload_first !== want.first ||
                   rsp_payload_second !== want.second) begin
                  bad_count++;
                  if (bad_count <= 10) begin
                     $display("%0t: frame mismatch, expected kind %0d ts %h level %h pay %h %h",
                              $realtime, want.kind, want.ts, want.level, want.first,
                              want.second);
                     $display("%0t:                 got kind %0d ts %h level %h pay %h %h",
                              $realtime, rsp_frame_kind, rsp_timestamp, rsp_signal_level,
                              rsp_payload_first, rsp_payload_second);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            absorb_rx_byte(req_rx_byte);
         end
      end
      mismatches <= bad_count;
      outstanding <= frames_due.size();
      frames_checked <= checked_count;
   end

endmodule

// ----- sim/tb_mode_s_escaped_frame_deframer.sv -----
// Testbench top for the escaped-frame deframer: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module tb_mode_s_escaped_frame_deframer;
   import msefd_pkg::*;

   localparam int unsigned ITEM_TARGET = 1150;
   localparam int unsigned QUIET_TAIL  = 200;
   localparam int unsigned IDLE_LIMIT  = 1000;
   localparam logic [BYTE_W-1:0] MODE_AC_TYPE = 8'h31;

   logic clock = 1'b0;
   logic reset = 1'b1;

   msefd_req_if req_if ();
   msefd_rsp_if rsp_if ();

   int          mismatches;
   int          outstanding;
   int          frames_checked;
   int          idle_pct = 0;
   int unsigned sent = 0;
   int unsigned idle_cycles = 0;

   logic [BYTE_W-1:0] corner_pay [SHORT_BYTES] =
      '{8'h1a, 8'h00, 8'hff, 8'h80, 8'h01, 8'h7f, 8'h1a};

   mode_s_escaped_frame_deframer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   msefd_frame_checker checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_if.valid),
      .req_ready          (req_if.ready),
      .req_rx_byte        (req_if.rx_byte),
      .rsp_valid          (rsp_if.valid),
      .rsp_ready          (rsp_if.ready),
      .rsp_frame_kind     (rsp_if.frame_kind),
      .rsp_timestamp      (rsp_if.timestamp),
      .rsp_signal_level   (rsp_if.signal_level),
      .rsp_payload_first  (rsp_if.payload_first),
      .rsp_payload_second (rsp_if.payload_second),
      .mismatches         (mismatches),
      .outstanding        (outstanding),
      .frames_checked     (frames_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Result side back-pressure in random bursts.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   function automatic logic [BYTE_W-1:0] rand_byte();
      case ($urandom_range(0, 9))
         0, 1:    return ESC_BYTE;
         2:       return 8'h00;
         3:       return LEVEL_MAX;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.rx_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sent++;
   endtask

   // A data byte equal to the frame marker goes out doubled.
   task automatic send_data(input logic [BYTE_W-1:0] b);
      send_byte(b);
      if (b == ESC_BYTE) begin
         send_byte(b);
      end
   endtask

   task automatic send_frame(input bit long_kind, input int unsigned keep);
      send_byte(ESC_BYTE);
      send_byte(long_kind ? TYPE_LONG : TYPE_SHORT);
      for (int unsigned i = 0; i < keep; i++) begin
         send_data(rand_byte());
      end
   endtask

   initial begin
      bit          long_kind;
      int unsigned full;
      int unsigned pick;
      req_if.valid = 1'b0;
      req_if.rx_byte = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: stray bytes, a mode A/C header, a doubled marker as type,
      // then a short frame with all-ones timestamp, the top signal level and escapes.
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(ESC_BYTE);
      send_byte(MODE_AC_TYPE);
      send_byte(ESC_BYTE);
      send_byte(ESC_BYTE);
      send_byte(ESC_BYTE);
      send_byte(TYPE_SHORT);
      repeat (HEAD_LEN) send_data(LEVEL_MAX);
      foreach (corner_pay[i]) send_data(corner_pay[i]);

      while (sent < ITEM_TARGET) begin
         if (sent >= ITEM_TARGET - QUIET_TAIL) begin
            idle_pct = 0;
         end else if ($urandom_range(0, 19) == 0) begin
            case ($urandom_range(0, 2))
               0:       idle_pct = 0;
               1:       idle_pct = 10;
               default: idle_pct = 35;
            endcase
         end
         long_kind = 1'($urandom_range(0, 1));
         full = HEAD_LEN + (long_kind ? LONG_BYTES : SHORT_BYTES);
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            send_frame(long_kind, full);
         end else if (pick < 80) begin
            send_frame(long_kind, $urandom_range(0, full - 1));
            if ($urandom_range(0, 1)) begin
               send_byte(ESC_BYTE);
               send_byte(rand_byte());
            end
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 5)) send_byte(rand_byte());
         end else if (pick < 95) begin
            send_byte(ESC_BYTE);
            send_byte($urandom_range(0, 1) ? MODE_AC_TYPE : BYTE_W'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 4)) send_byte(rand_byte());
         end else begin
            send_byte(ESC_BYTE);
            send_byte(ESC_BYTE);
         end
      end
      req_if.valid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Run covered %0d request bytes and %0d checked frames: short and long frames,",
               sent, frames_checked);
      $display("escaped data, abandoned frames, unknown types and stray bytes, with stalls.");
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/msefd_pkg.sv
src/msefd_if.sv
src/mode_s_escaped_frame_deframer.sv
sim/msefd_frame_checker.sv
sim/tb_mode_s_escaped_frame_deframer.sv
